// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication that holds from one edge to the same edge.
`define ASSERT_SAME(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Implication that holds from one edge to the next.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ----- hdl/acs_pkg.sv -----
`timescale 1ns / 1ps
package acs_pkg;
  localparam int MEM_WORDS = 256;
  localparam int AW = $clog2(MEM_WORDS);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [1:0] RUN_OK   = 2'd0;
  localparam logic [1:0] RUN_HALT = 2'd1;
  localparam logic [1:0] RUN_DIV0 = 2'd2;

  localparam logic [2:0] M_ACC  = 3'd0;
  localparam logic [2:0] M_IND  = 3'd1;
  localparam logic [2:0] M_POP  = 3'd2;
  localparam logic [2:0] M_PUSH = 3'd3;
  localparam logic [2:0] M_IMM  = 3'd4;
  localparam logic [2:0] M_ABS  = 3'd5;
  localparam logic [2:0] M_DISP = 3'd6;
  localparam logic [2:0] M_REL  = 3'd7;

  localparam logic [4:0] I_CALL  = 5'd0;
  localparam logic [4:0] I_JMP   = 5'd1;
  localparam logic [4:0] I_JZ    = 5'd2;
  localparam logic [4:0] I_JNZ   = 5'd3;
  localparam logic [4:0] I_NANDA = 5'd4;
  localparam logic [4:0] I_NANDM = 5'd5;
  localparam logic [4:0] I_INC   = 5'd6;
  localparam logic [4:0] I_DEC   = 5'd7;
  localparam logic [4:0] I_ADDM  = 5'd8;
  localparam logic [4:0] I_SUBM  = 5'd9;
  localparam logic [4:0] I_MULM  = 5'd10;
  localparam logic [4:0] I_DIVM  = 5'd11;
  localparam logic [4:0] I_MODM  = 5'd12;
  localparam logic [4:0] I_SNE   = 5'd13;
  localparam logic [4:0] I_SGE   = 5'd14;
  localparam logic [4:0] I_SLE   = 5'd15;
  localparam logic [4:0] I_ADDA  = 5'd16;
  localparam logic [4:0] I_SUBA  = 5'd17;
  localparam logic [4:0] I_MULA  = 5'd18;
  localparam logic [4:0] I_DIVA  = 5'd19;
  localparam logic [4:0] I_MODA  = 5'd20;
  localparam logic [4:0] I_SEQ   = 5'd21;
  localparam logic [4:0] I_SLT   = 5'd22;
  localparam logic [4:0] I_SGT   = 5'd23;
  localparam logic [4:0] I_LEA   = 5'd24;
  localparam logic [4:0] I_LSP   = 5'd25;
  localparam logic [4:0] I_LDA   = 5'd26;
  localparam logic [4:0] I_STA   = 5'd27;
  localparam logic [4:0] I_INCH  = 5'd28;
  localparam logic [4:0] I_OUTCH = 5'd29;
  localparam logic [4:0] I_INNUM = 5'd30;

  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [7:0] divisor;
  } acs_div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quot;
    logic [7:0] rem;
  } acs_div_rsp_t;
endpackage

// ----- hdl/accumulator_cpu_step.sv -----
`timescale 1ns / 1ps
// Channel  Handshake             Payload
// in       in_valid / in_ready   in_command, in_address, in_data, in_input_eof
// out      out_valid / out_ready out_read_data .. out_sp_value
// After reset a clearing pass zeroes all 256 memory words; no beat is taken meanwhile.
// A divide or remainder step also waits for the acs_div divider.
// A step walks the single-port memory in order: fetch, operand byte, target read, write-back.
// The result register holds while out_ready is low; a new beat waits until it is taken.
module accumulator_cpu_step (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [7:0] in_address,
  input  logic [7:0] in_data,
  input  logic       in_input_eof,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_out_valid,
  output logic       out_out_kind,
  output logic [7:0] out_out_value,
  output logic       out_input_taken,
  output logic [1:0] out_run_state,
  output logic [7:0] out_acc_value,
  output logic [7:0] out_ip_value,
  output logic [7:0] out_sp_value
);
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RDW   = 4'd2;
  localparam logic [3:0] S_FET   = 4'd3;
  localparam logic [3:0] S_OPB   = 4'd4;
  localparam logic [3:0] S_ADR   = 4'd5;
  localparam logic [3:0] S_TGT   = 4'd6;
  localparam logic [3:0] S_EXE   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_WB    = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_WAIT  = 4'd11;

  logic [7:0] mem [acs_pkg::MEM_WORDS];
  logic [acs_pkg::AW-1:0] maddr;
  logic       mwe;
  logic [7:0] mwd;
  logic [7:0] mrd_r;

  logic [3:0] st_r, st_nxt;
  logic [acs_pkg::AW-1:0] clr_r, clr_nxt;
  logic [7:0] din_r, din_nxt;
  logic       eof_r, eof_nxt;
  logic [7:0] acc_r, acc_nxt, ip_r, ip_nxt, sp_r, sp_nxt;
  logic [1:0] hs_r, hs_nxt;
  logic [7:0] opc_r, opc_nxt, t_r, t_nxt, m_r, m_nxt, ip0_r, ip0_nxt, wv_r, wv_nxt;
  logic       tacc_r, tacc_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] rd_r, rd_nxt, oval_r, oval_nxt;
  logic       oo_r, oo_nxt, ok_r, ok_nxt, it_r, it_nxt;
  acs_pkg::acs_div_req_t dreq;
  acs_pkg::acs_div_rsp_t drsp;
  logic [2:0] mode;
  logic [4:0] ins;
  logic [15:0] prod;
  logic [7:0] opr;
  logic       dov;

  acs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwd;
    mrd_r <= mem[maddr];
  end

  assign mode = opc_r[2:0];
  assign ins = opc_r[7:3];
  assign in_ready = (st_r == S_IDLE);

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; din_nxt = din_r;
    eof_nxt = eof_r; acc_nxt = acc_r; ip_nxt = ip_r; sp_nxt = sp_r; hs_nxt = hs_r;
    opc_nxt = opc_r; t_nxt = t_r; m_nxt = m_r; ip0_nxt = ip0_r; wv_nxt = wv_r;
    tacc_nxt = tacc_r; ov_nxt = ov_r; rd_nxt = rd_r; oval_nxt = oval_r;
    oo_nxt = oo_r; ok_nxt = ok_r; it_nxt = it_r;
    maddr = ip_r; mwe = 1'b0; mwd = 8'd0;
    dreq.start = 1'b0; dreq.dividend = 8'd0; dreq.divisor = 8'd0;
    opr = tacc_r ? acc_r : m_r;
    prod = acc_r * opr;
    dov = 1'b0;
    case (st_r)
      S_CLR: begin
        maddr = clr_r; mwe = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {acs_pkg::AW{1'b1}}) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          din_nxt = in_data;
          eof_nxt = in_input_eof;
          rd_nxt = 8'd0; oo_nxt = 1'b0; ok_nxt = 1'b0; oval_nxt = 8'd0; it_nxt = 1'b0;
          if (in_command == acs_pkg::CMD_WRITE) begin
            maddr = in_address; mwe = 1'b1; mwd = in_data; st_nxt = S_OUT;
          end else if (in_command == acs_pkg::CMD_READ) begin
            maddr = in_address; st_nxt = S_RDW;
          end else if (in_command == acs_pkg::CMD_STEP && hs_r == acs_pkg::RUN_OK) begin
            maddr = ip_r; ip0_nxt = ip_r; st_nxt = S_FET;
          end else begin
            st_nxt = S_OUT;
          end
        end
      end
      S_RDW: begin
        rd_nxt = mrd_r; st_nxt = S_OUT;
      end
      S_FET: begin
        opc_nxt = mrd_r; maddr = ip0_r + 8'd1; st_nxt = S_OPB;
      end
      S_OPB: begin
        tacc_nxt = 1'b0;
        case (mode)
          acs_pkg::M_ACC: tacc_nxt = 1'b1;
          acs_pkg::M_IND: t_nxt = acc_r;
          acs_pkg::M_POP: begin t_nxt = sp_r; sp_nxt = sp_r + 8'd1; end
          acs_pkg::M_PUSH: begin t_nxt = sp_r - 8'd1; sp_nxt = sp_r - 8'd1; end
          acs_pkg::M_IMM: t_nxt = ip0_r + 8'd1;
          acs_pkg::M_ABS: t_nxt = mrd_r;
          acs_pkg::M_DISP: t_nxt = mrd_r + sp_r;
          default: t_nxt = mrd_r + ip0_r + 8'd2;
        endcase
        ip_nxt = ip0_r + ((mode < acs_pkg::M_IMM) ? 8'd1 : 8'd2);
        st_nxt = S_ADR;
      end
      S_ADR: begin
        maddr = t_r; st_nxt = S_TGT;
        if (tacc_r && (ins <= acs_pkg::I_JNZ || ins == acs_pkg::I_LEA
            || ins == acs_pkg::I_LSP)) begin
          hs_nxt = acs_pkg::RUN_HALT; st_nxt = S_OUT;
        end
      end
      S_TGT: begin
        m_nxt = mrd_r; st_nxt = S_EXE;
      end
      S_EXE: begin
        st_nxt = S_WB; wv_nxt = 8'd0;
        case (ins)
          acs_pkg::I_CALL: begin acc_nxt = ip_r; ip_nxt = t_r; st_nxt = S_OUT; end
          acs_pkg::I_JMP: begin ip_nxt = t_r; st_nxt = S_OUT; end
          acs_pkg::I_JZ: begin if (acc_r == 8'd0) ip_nxt = t_r; st_nxt = S_OUT; end
          acs_pkg::I_JNZ: begin if (acc_r != 8'd0) ip_nxt = t_r; st_nxt = S_OUT; end
          acs_pkg::I_NANDA: begin acc_nxt = ~(acc_r & opr); st_nxt = S_OUT; end
          acs_pkg::I_NANDM: wv_nxt = ~(acc_r & opr);
          acs_pkg::I_INC: wv_nxt = opr + 8'd1;
          acs_pkg::I_DEC: wv_nxt = opr - 8'd1;
          acs_pkg::I_ADDM: wv_nxt = opr + acc_r;
          acs_pkg::I_SUBM: wv_nxt = opr - acc_r;
          acs_pkg::I_MULM: wv_nxt = prod[7:0];
          acs_pkg::I_DIVM, acs_pkg::I_MODM: begin
            dov = 1'b1; dreq.dividend = opr; dreq.divisor = acc_r;
          end
          acs_pkg::I_DIVA, acs_pkg::I_MODA: begin
            dov = 1'b1; dreq.dividend = acc_r; dreq.divisor = opr;
          end
          acs_pkg::I_SNE: begin if (acc_r != opr) ip_nxt = ip_r + 8'd2; st_nxt = S_OUT; end
          acs_pkg::I_SGE: begin if (acc_r >= opr) ip_nxt = ip_r + 8'd2; st_nxt = S_OUT; end
          acs_pkg::I_SLE: begin if (acc_r <= opr) ip_nxt = ip_r + 8'd2; st_nxt = S_OUT; end
          acs_pkg::I_ADDA: begin acc_nxt = opr + acc_r; st_nxt = S_OUT; end
          acs_pkg::I_SUBA: begin acc_nxt = acc_r - opr; st_nxt = S_OUT; end
          acs_pkg::I_MULA: begin acc_nxt = prod[7:0]; st_nxt = S_OUT; end
          acs_pkg::I_SEQ: begin if (acc_r == opr) ip_nxt = ip_r + 8'd2; st_nxt = S_OUT; end
          acs_pkg::I_SLT: begin if (acc_r < opr) ip_nxt = ip_r + 8'd2; st_nxt = S_OUT; end
          acs_pkg::I_SGT: begin if (acc_r > opr) ip_nxt = ip_r + 8'd2; st_nxt = S_OUT; end
          acs_pkg::I_LEA: begin acc_nxt = t_r; st_nxt = S_OUT; end
          acs_pkg::I_LSP: begin sp_nxt = t_r; st_nxt = S_OUT; end
          acs_pkg::I_LDA: begin acc_nxt = opr; st_nxt = S_OUT; end
          acs_pkg::I_STA: wv_nxt = acc_r;
          acs_pkg::I_INCH, acs_pkg::I_INNUM: begin
            wv_nxt = eof_r ? 8'hFF : din_r; it_nxt = ~eof_r;
          end
          acs_pkg::I_OUTCH: begin
            oo_nxt = 1'b1; ok_nxt = 1'b0; oval_nxt = opr; st_nxt = S_OUT;
          end
          default: begin
            oo_nxt = 1'b1; ok_nxt = 1'b1; oval_nxt = opr; st_nxt = S_OUT;
          end
        endcase
        if (dov) begin
          if (dreq.divisor == 8'd0) begin
            hs_nxt = acs_pkg::RUN_DIV0; st_nxt = S_OUT;
          end else begin
            dreq.start = 1'b1; st_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          if (ins == acs_pkg::I_DIVM) begin wv_nxt = drsp.quot; st_nxt = S_WB; end
          else if (ins == acs_pkg::I_MODM) begin wv_nxt = drsp.rem; st_nxt = S_WB; end
          else if (ins == acs_pkg::I_DIVA) begin acc_nxt = drsp.quot; st_nxt = S_OUT; end
          else begin acc_nxt = drsp.rem; st_nxt = S_OUT; end
        end
      end
      S_WB: begin
        if (tacc_r) acc_nxt = wv_r;
        else begin maddr = t_r; mwe = 1'b1; mwd = wv_r; end
        st_nxt = S_OUT;
      end
      S_OUT: begin
        ov_nxt = 1'b1; st_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (out_ready) begin ov_nxt = 1'b0; st_nxt = S_IDLE; end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; acc_r <= 8'd0; ip_r <= 8'd0; sp_r <= 8'd0;
      hs_r <= acs_pkg::RUN_OK; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; acc_r <= acc_nxt; ip_r <= ip_nxt;
      sp_r <= sp_nxt; hs_r <= hs_nxt; ov_r <= ov_nxt;
    end
    din_r <= din_nxt; eof_r <= eof_nxt;
    opc_r <= opc_nxt; t_r <= t_nxt; m_r <= m_nxt; ip0_r <= ip0_nxt; wv_r <= wv_nxt;
    tacc_r <= tacc_nxt; rd_r <= rd_nxt; oval_r <= oval_nxt; oo_r <= oo_nxt;
    ok_r <= ok_nxt; it_r <= it_nxt;
  end

  assign out_valid = ov_r;
  assign out_read_data = rd_r;
  assign out_out_valid = oo_r;
  assign out_out_kind = ok_r;
  assign out_out_value = oval_r;
  assign out_input_taken = it_r;
  assign out_run_state = hs_r;
  assign out_acc_value = acc_r;
  assign out_ip_value = ip_r;
  assign out_sp_value = sp_r;
endmodule

// ----- hdl/acs_div.sv -----
`timescale 1ns / 1ps
module acs_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  acs_pkg::acs_div_req_t req,
  output acs_pkg::acs_div_rsp_t rsp
);
  logic       busy_r, busy_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] q_r, q_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] d_r, d_nxt;
  logic       done_r, done_nxt;
  logic [8:0] trial;
  logic [8:0] diff;

  always_comb begin
    trial = {rem_r, q_r[7]};
    diff = trial - {1'b0, d_r};
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 3'd0;
      q_nxt = req.dividend;
      rem_nxt = 8'd0;
      d_nxt = req.divisor;
    end else if (busy_r) begin
      if (!diff[8]) begin
        rem_nxt = diff[7:0];
        q_nxt = {q_r[6:0], 1'b1};
      end else begin
        rem_nxt = trial[7:0];
        q_nxt = {q_r[6:0], 1'b0};
      end
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem = rem_r;
endmodule

// ----- hdl/acs_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module acs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_out_valid,
  input logic       out_out_kind,
  input logic [7:0] out_out_value,
  input logic       out_input_taken,
  input logic [1:0] out_run_state
);
  `ASSERT_SAME(a_excl, clk, rst_n, out_valid, !in_ready)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_SAME(a_kind, clk, rst_n, out_valid && !out_out_valid, !out_out_kind && out_out_value == 8'd0)
  `ASSERT_SAME(a_io, clk, rst_n, out_valid && out_input_taken, !out_out_valid)
  `ASSERT_SAME(a_rs, clk, rst_n, out_valid, out_run_state != 2'd3)
endmodule

bind accumulator_cpu_step acs_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_out_valid(out_out_valid),
  .out_out_kind(out_out_kind), .out_out_value(out_out_value),
  .out_input_taken(out_input_taken), .out_run_state(out_run_state)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [4:0] I_OUTNUM = 5'd31;
  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [7:0] rd;
    logic       ov;
    logic       kind;
    logic [7:0] oval;
    logic       taken;
    logic [1:0] rs;
    logic [7:0] acc;
    logic [7:0] ip;
    logic [7:0] sp;
  } step_res_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] addr;
    logic [7:0] data;
    logic       eof;
    logic       chk;
    step_res_t  res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready, in_input_eof;
  logic [1:0] in_command;
  logic [7:0] in_address, in_data;
  logic out_valid, out_ready;
  logic [7:0] out_read_data, out_out_value, out_acc_value, out_ip_value, out_sp_value;
  logic out_out_valid, out_out_kind, out_input_taken;
  logic [1:0] out_run_state;

  logic [7:0] mem_m [256];
  logic [7:0] acc_m, ip_m, sp_m;
  logic [1:0] halt_m;

  step_res_t result_q[$];
  int errors = 0;
  int cycles = 0;
  int p_send = 18;
  int p_recv = 67;

  accumulator_cpu_step dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  localparam int NDIR = 24;
  dir_row_t dir_tab [NDIR] = '{
    '{acs_pkg::CMD_READ,  8'd0,   8'd0,   1'b0, 1'b1, '0},
    '{acs_pkg::CMD_READ,  8'd255, 8'd0,   1'b0, 1'b1, '0},
    '{acs_pkg::CMD_WRITE, 8'd0,   {acs_pkg::I_INCH, acs_pkg::M_IMM}, 1'b0, 1'b1, '0},
    '{acs_pkg::CMD_WRITE, 8'd255, 8'd255, 1'b0, 1'b1, '0},
    '{acs_pkg::CMD_STEP,  8'd0,   8'hFF,  1'b0, 1'b1,
      '{8'd0, 1'b0, 1'b0, 8'd0, 1'b1, acs_pkg::RUN_OK, 8'd0, 8'd2, 8'd0}},
    '{acs_pkg::CMD_WRITE, 8'd2,   {acs_pkg::I_INNUM, acs_pkg::M_PUSH}, 1'b0, 1'b0, '0},
    '{acs_pkg::CMD_STEP,  8'd0,   8'd0,   1'b1, 1'b1,
      '{8'd0, 1'b0, 1'b0, 8'd0, 1'b0, acs_pkg::RUN_OK, 8'd0, 8'd3, 8'd255}},
    '{acs_pkg::CMD_WRITE, 8'd3,   {acs_pkg::I_LDA, acs_pkg::M_POP}, 1'b0, 1'b0, '0},
    '{acs_pkg::CMD_STEP,  8'd0,   8'd0,   1'b0, 1'b0, '0},
    '{acs_pkg::CMD_WRITE, 8'd4,   {I_OUTNUM, acs_pkg::M_ACC}, 1'b0, 1'b0, '0},
    '{acs_pkg::CMD_STEP,  8'd0,   8'd0,   1'b0, 1'b0, '0},
    '{acs_pkg::CMD_WRITE, 8'd5,   {acs_pkg::I_MULA, acs_pkg::M_IMM}, 1'b0, 1'b0, '0},
    '{acs_pkg::CMD_WRITE, 8'd6,   8'hFF,  1'b0, 1'b0, '0},
    '{acs_pkg::CMD_STEP,  8'd0,   8'd0,   1'b0, 1'b0, '0},
    '{acs_pkg::CMD_WRITE, 8'd7,   {acs_pkg::I_SEQ, acs_pkg::M_REL}, 1'b0, 1'b0, '0},
    '{acs_pkg::CMD_WRITE, 8'd8,   8'd0,   1'b0, 1'b0, '0},
    '{acs_pkg::CMD_STEP,  8'd0,   8'd0,   1'b0, 1'b0, '0},
    '{acs_pkg::CMD_WRITE, 8'd9,   {acs_pkg::I_OUTCH, acs_pkg::M_IND}, 1'b0, 1'b0, '0},
    '{acs_pkg::CMD_STEP,  8'd0,   8'd0,   1'b0, 1'b0, '0},
    '{acs_pkg::CMD_WRITE, 8'd10,  {acs_pkg::I_CALL, acs_pkg::M_DISP}, 1'b0, 1'b0, '0},
    '{acs_pkg::CMD_WRITE, 8'd11,  8'h20,  1'b0, 1'b0, '0},
    '{acs_pkg::CMD_STEP,  8'd0,   8'd0,   1'b0, 1'b0, '0},
    '{CMD_NONE,           8'hAA,  8'h55,  1'b1, 1'b0, '0},
    '{acs_pkg::CMD_READ,  8'h80,  8'd0,   1'b0, 1'b0, '0}
  };

  function automatic step_res_t machine_step(logic [1:0] cmd, logic [7:0] addr,
                                             logic [7:0] data, logic eof);
    step_res_t r;
    logic [7:0] opc, nxt, tgt, a, m, ip0, wv;
    logic [2:0] mode;
    logic [4:0] ins;
    logic on_acc, we;
    r = '0;
    if (cmd == acs_pkg::CMD_WRITE) begin
      mem_m[addr] = data;
    end else if (cmd == acs_pkg::CMD_READ) begin
      r.rd = mem_m[addr];
    end else if (cmd == acs_pkg::CMD_STEP && halt_m == acs_pkg::RUN_OK) begin
      opc = mem_m[ip_m];
      mode = opc[2:0];
      ins = opc[7:3];
      ip0 = ip_m;
      nxt = mem_m[ip0 + 8'd1];
      on_acc = 1'b0;
      tgt = 8'd0;
      we = 1'b0;
      wv = 8'd0;
      case (mode)
        acs_pkg::M_ACC: on_acc = 1'b1;
        acs_pkg::M_IND: tgt = acc_m;
        acs_pkg::M_POP: begin
          tgt = sp_m;
          sp_m = sp_m + 8'd1;
        end
        acs_pkg::M_PUSH: begin
          sp_m = sp_m - 8'd1;
          tgt = sp_m;
        end
        acs_pkg::M_IMM: tgt = ip0 + 8'd1;
        acs_pkg::M_ABS: tgt = nxt;
        acs_pkg::M_DISP: tgt = nxt + sp_m;
        default: tgt = nxt + ip0 + 8'd2;
      endcase
      ip_m = ip0 + ((mode < acs_pkg::M_IMM) ? 8'd1 : 8'd2);
      a = acc_m;
      m = on_acc ? acc_m : mem_m[tgt];
      if ((ins <= acs_pkg::I_JNZ || ins == acs_pkg::I_LEA || ins == acs_pkg::I_LSP)
          && mode == acs_pkg::M_ACC) begin
        halt_m = acs_pkg::RUN_HALT;
      end else begin
        case (ins)
          acs_pkg::I_CALL: begin
            acc_m = ip_m;
            ip_m = tgt;
          end
          acs_pkg::I_JMP: ip_m = tgt;
          acs_pkg::I_JZ: if (a == 0) ip_m = tgt;
          acs_pkg::I_JNZ: if (a != 0) ip_m = tgt;
          acs_pkg::I_NANDA: acc_m = ~(a & m);
          acs_pkg::I_NANDM: begin we = 1'b1; wv = ~(m & a); end
          acs_pkg::I_INC: begin we = 1'b1; wv = m + 8'd1; end
          acs_pkg::I_DEC: begin we = 1'b1; wv = m - 8'd1; end
          acs_pkg::I_ADDM: begin we = 1'b1; wv = m + a; end
          acs_pkg::I_SUBM: begin we = 1'b1; wv = m - a; end
          acs_pkg::I_MULM: begin we = 1'b1; wv = m * a; end
          acs_pkg::I_DIVM:
            if (a == 0) halt_m = acs_pkg::RUN_DIV0; else begin we = 1'b1; wv = m / a; end
          acs_pkg::I_MODM:
            if (a == 0) halt_m = acs_pkg::RUN_DIV0; else begin we = 1'b1; wv = m % a; end
          acs_pkg::I_SNE: if (a != m) ip_m = ip_m + 8'd2;
          acs_pkg::I_SGE: if (a >= m) ip_m = ip_m + 8'd2;
          acs_pkg::I_SLE: if (a <= m) ip_m = ip_m + 8'd2;
          acs_pkg::I_ADDA: acc_m = m + a;
          acs_pkg::I_SUBA: acc_m = a - m;
          acs_pkg::I_MULA: acc_m = a * m;
          acs_pkg::I_DIVA: if (m == 0) halt_m = acs_pkg::RUN_DIV0; else acc_m = a / m;
          acs_pkg::I_MODA: if (m == 0) halt_m = acs_pkg::RUN_DIV0; else acc_m = a % m;
          acs_pkg::I_SEQ: if (a == m) ip_m = ip_m + 8'd2;
          acs_pkg::I_SLT: if (a < m) ip_m = ip_m + 8'd2;
          acs_pkg::I_SGT: if (a > m) ip_m = ip_m + 8'd2;
          acs_pkg::I_LEA: acc_m = tgt;
          acs_pkg::I_LSP: sp_m = tgt;
          acs_pkg::I_LDA: acc_m = m;
          acs_pkg::I_STA: begin we = 1'b1; wv = a; end
          acs_pkg::I_INCH, acs_pkg::I_INNUM: begin
            we = 1'b1;
            wv = eof ? 8'hFF : data;
            r.taken = !eof;
          end
          acs_pkg::I_OUTCH: begin r.ov = 1'b1; r.oval = m; end
          default: begin r.ov = 1'b1; r.kind = 1'b1; r.oval = m; end
        endcase
        if (we) begin
          if (on_acc) acc_m = wv;
          else mem_m[tgt] = wv;
        end
      end
    end
    r.rs = halt_m;
    r.acc = acc_m;
    r.ip = ip_m;
    r.sp = sp_m;
    return r;
  endfunction

  function automatic bit step_halts(logic [7:0] opc, logic [7:0] data, logic eof);
    logic [7:0] mem_save [256];
    logic [7:0] a0, i0, s0;
    logic [1:0] h0;
    step_res_t r;
    bit halts;
    mem_save = mem_m;
    a0 = acc_m;
    i0 = ip_m;
    s0 = sp_m;
    h0 = halt_m;
    mem_m[ip_m] = opc;
    r = machine_step(acs_pkg::CMD_STEP, 8'd0, data, eof);
    halts = (r.rs != acs_pkg::RUN_OK);
    mem_m = mem_save;
    acc_m = a0;
    ip_m = i0;
    sp_m = s0;
    halt_m = h0;
    return halts;
  endfunction

  task automatic send_beat(logic [1:0] cmd, logic [7:0] addr, logic [7:0] data,
                           logic eof, logic chk, step_res_t typed);
    step_res_t r;
    while ($urandom_range(99) < p_send) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_address <= addr;
    in_data <= data;
    in_input_eof <= eof;
    do @(posedge clk); while (!in_ready);
    r = machine_step(cmd, addr, data, eof);
    result_q.push_back(chk ? typed : r);
  endtask

  always @(posedge clk) begin
    step_res_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      got = '{out_read_data, out_out_valid, out_out_kind, out_out_value, out_input_taken,
              out_run_state, out_acc_value, out_ip_value, out_sp_value};
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat %p", got);
      end else begin
        want = result_q.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= p_recv);
  end

  initial begin
    logic [7:0] opc;
    logic [7:0] d;
    logic e;
    int pick;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= acs_pkg::CMD_WRITE;
    in_address <= 8'd0;
    in_data <= 8'd0;
    in_input_eof <= 1'b0;
    out_ready <= 1'b0;
    foreach (mem_m[i]) mem_m[i] = 8'd0;
    acc_m = 8'd0;
    ip_m = 8'd0;
    sp_m = 8'd0;
    halt_m = acs_pkg::RUN_OK;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NDIR; i++)
      send_beat(dir_tab[i].cmd, dir_tab[i].addr, dir_tab[i].data, dir_tab[i].eof,
                dir_tab[i].chk, dir_tab[i].res);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= 2 * RANDOM_ITEMS / 3) begin
        p_send = 0;
        p_recv = 0;
      end else if (n >= RANDOM_ITEMS / 3) begin
        p_send = 67;
        p_recv = 18;
      end
      pick = $urandom_range(99);
      d = 8'($urandom);
      e = ($urandom_range(3) == 0);
      if (pick < 8) begin
        send_beat(acs_pkg::CMD_WRITE, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
      end else if (pick < 13) begin
        send_beat(acs_pkg::CMD_READ, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
      end else if (pick < 15) begin
        send_beat(CMD_NONE, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, '0);
      end else begin
        if ($urandom_range(99) < 40) begin
          send_beat(acs_pkg::CMD_WRITE, ip_m, 8'($urandom), 1'b0, 1'b0, '0);
          n++;
        end
        if ($urandom_range(99) < 30) begin
          send_beat(acs_pkg::CMD_WRITE, ip_m + 8'd1, 8'($urandom), 1'b0, 1'b0, '0);
          n++;
        end
        if (step_halts(mem_m[ip_m], d, e)) begin
          do opc = 8'($urandom); while (step_halts(opc, d, e));
          send_beat(acs_pkg::CMD_WRITE, ip_m, opc, 1'b0, 1'b0, '0);
          n++;
        end
        send_beat(acs_pkg::CMD_STEP, 8'($urandom), d, e, 1'b0, '0);
      end
    end

    // The machine can only halt once, so the halting case comes last.
    if ($urandom_range(1) == 0) begin
      send_beat(acs_pkg::CMD_WRITE, ip_m + 8'd1, 8'd0, 1'b0, 1'b0, '0);
      send_beat(acs_pkg::CMD_WRITE, ip_m, {acs_pkg::I_DIVA, acs_pkg::M_IMM}, 1'b0, 1'b0, '0);
    end else begin
      send_beat(acs_pkg::CMD_WRITE, ip_m, {acs_pkg::I_JMP, acs_pkg::M_ACC}, 1'b0, 1'b0, '0);
    end
    send_beat(acs_pkg::CMD_STEP, 8'd0, 8'd0, 1'b0, 1'b0, '0);
    send_beat(acs_pkg::CMD_STEP, 8'd0, 8'd0, 1'b0, 1'b0, '0);
    send_beat(acs_pkg::CMD_WRITE, 8'h40, 8'h5A, 1'b0, 1'b0, '0);
    send_beat(acs_pkg::CMD_READ, 8'h40, 8'd0, 1'b0, 1'b0, '0);
    in_valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
